// File: hdl/acc_tilt_pkg.sv
// Shared widths, constants, lane state types and the CORDIC angle table for the tilt monitor.
package acc_tilt_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int MAG_W        = 16;
    localparam int SQ_W         = 31;
    localparam int DEN_W        = 32;
    localparam int ROOT_W       = 32;
    localparam int REM_W        = 34;
    localparam int XY_W         = 37;
    localparam int Z_W          = 25;
    localparam int DEG_W        = 8;
    localparam int LIMIT_W      = 7;
    localparam int ANGLE_FRAC   = 16;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_ITERS = 20;

    localparam logic signed [Z_W-1:0]   TRUNC_BIAS  = 25'sd32;
    localparam logic [LIMIT_W-1:0]      RIGHT_ANGLE = 7'd90;
    localparam logic [LIMIT_W-1:0]      LIMIT_RESET = 7'd30;

    typedef struct packed {
        logic             neg;
        logic             num_zero;
        logic             den_zero;
        logic [MAG_W-1:0] mag;
    } lane_info_t;

    typedef struct packed {
        logic [DEN_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        lane_info_t        info;
    } sqrt_state_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        lane_info_t             info;
    } cordic_state_t;

    // atan(2^-i) in degrees, Q16, rounded to nearest.
    function automatic logic [Z_W-1:0] atan_q16(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:       v = 25'd2949120;
            1:       v = 25'd1740967;
            2:       v = 25'd919879;
            3:       v = 25'd466945;
            4:       v = 25'd234379;
            5:       v = 25'd117304;
            6:       v = 25'd58666;
            7:       v = 25'd29335;
            8:       v = 25'd14668;
            9:       v = 25'd7334;
            10:      v = 25'd3667;
            11:      v = 25'd1833;
            12:      v = 25'd917;
            13:      v = 25'd458;
            14:      v = 25'd229;
            15:      v = 25'd115;
            16:      v = 25'd57;
            17:      v = 25'd29;
            18:      v = 25'd14;
            19:      v = 25'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/acc_tilt_front.sv
// Front end: magnitudes, squares and sums of squares for the pitch and roll lanes.
module acc_tilt_front (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     en,
    input  logic                                     in_valid,
    input  logic signed [acc_tilt_pkg::SAMPLE_W-1:0] in_x,
    input  logic signed [acc_tilt_pkg::SAMPLE_W-1:0] in_y,
    input  logic signed [acc_tilt_pkg::SAMPLE_W-1:0] in_z,
    output logic                                     out_valid,
    output acc_tilt_pkg::sqrt_state_t                out_pitch,
    output acc_tilt_pkg::sqrt_state_t                out_roll
);
    import acc_tilt_pkg::*;

    logic             v1_reg, v2_reg, v3_reg;
    logic [MAG_W-1:0] mx_reg, my_reg, mz_reg;
    logic             nx_reg, ny_reg;
    logic [MAG_W-1:0] mx2_reg, my2_reg;
    logic             nx2_reg, ny2_reg;
    logic [SQ_W-1:0]  sx_reg, sy_reg, sz_reg;
    sqrt_state_t      pitch_reg, roll_reg;

    logic [MAG_W-1:0] mx_next, my_next, mz_next;
    logic [2*MAG_W-1:0] px, py, pz;
    logic [DEN_W-1:0] den_p, den_r;

    // Two's complement magnitude; the most negative sample maps to 32768.
    assign mx_next = in_x[SAMPLE_W-1] ? MAG_W'(~in_x + 1'b1) : MAG_W'(in_x);
    assign my_next = in_y[SAMPLE_W-1] ? MAG_W'(~in_y + 1'b1) : MAG_W'(in_y);
    assign mz_next = in_z[SAMPLE_W-1] ? MAG_W'(~in_z + 1'b1) : MAG_W'(in_z);

    assign px = (2*MAG_W)'(mx_reg) * (2*MAG_W)'(mx_reg);
    assign py = (2*MAG_W)'(my_reg) * (2*MAG_W)'(my_reg);
    assign pz = (2*MAG_W)'(mz_reg) * (2*MAG_W)'(mz_reg);

    assign den_p = DEN_W'(sy_reg) + DEN_W'(sz_reg);
    assign den_r = DEN_W'(sx_reg) + DEN_W'(sz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            mz_reg  <= mz_next;
            nx_reg  <= in_x[SAMPLE_W-1];
            ny_reg  <= in_y[SAMPLE_W-1];

            sx_reg  <= px[SQ_W-1:0];
            sy_reg  <= py[SQ_W-1:0];
            sz_reg  <= pz[SQ_W-1:0];
            mx2_reg <= mx_reg;
            my2_reg <= my_reg;
            nx2_reg <= nx_reg;
            ny2_reg <= ny_reg;

            pitch_reg.rad           <= den_p;
            pitch_reg.rem           <= '0;
            pitch_reg.root          <= '0;
            pitch_reg.info.neg      <= nx2_reg;
            pitch_reg.info.num_zero <= (mx2_reg == '0);
            pitch_reg.info.den_zero <= (den_p == '0);
            pitch_reg.info.mag      <= mx2_reg;

            roll_reg.rad            <= den_r;
            roll_reg.rem            <= '0;
            roll_reg.root           <= '0;
            roll_reg.info.neg       <= ny2_reg;
            roll_reg.info.num_zero  <= (my2_reg == '0);
            roll_reg.info.den_zero  <= (den_r == '0);
            roll_reg.info.mag       <= my2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_pitch = pitch_reg;
    assign out_roll  = roll_reg;

endmodule

// File: hdl/acc_tilt_sqrt_cell.sv
// One digit step of the pipelined square root of den << 32.
module acc_tilt_sqrt_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  acc_tilt_pkg::sqrt_state_t in_st,
    output logic                      out_valid,
    output acc_tilt_pkg::sqrt_state_t out_st
);
    import acc_tilt_pkg::*;

    logic               valid_reg;
    sqrt_state_t        st_reg;
    sqrt_state_t        st_next;
    logic [REM_W+1:0]   cur;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   diff;
    logic               ge;

    // Bring down the next two radicand bits; the low 32 bits of den << 32 are
    // zeros, which the left shift of rad supplies once den is used up.
    assign cur   = {in_st.rem, in_st.rad[DEN_W-1 -: 2]};
    assign trial = (REM_W+2)'({in_st.root, 2'b01});
    assign ge    = (cur >= trial);
    assign diff  = cur - trial;

    always_comb begin
        st_next      = in_st;
        st_next.rad  = in_st.rad << 2;
        st_next.rem  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        st_next.root = {in_st.root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;

endmodule

// File: hdl/acc_tilt_cordic_cell.sv
// One vectoring iteration of the pipelined CORDIC with a fixed shift.
module acc_tilt_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  acc_tilt_pkg::cordic_state_t in_st,
    output logic                        out_valid,
    output acc_tilt_pkg::cordic_state_t out_st
);
    import acc_tilt_pkg::*;

    localparam logic signed [XY_W-1:0] RND  = XY_W'((64'd1 << SHIFT) - 64'd1);
    localparam logic signed [Z_W-1:0]  ATAN = signed'(atan_q16(SHIFT));

    logic                   valid_reg;
    cordic_state_t          st_reg;
    cordic_state_t          st_next;
    logic signed [XY_W-1:0] xs, ys;
    logic                   y_pos;

    // Shift that truncates toward zero: round negative values up before the shift.
    assign xs = in_st.x[XY_W-1] ? ((in_st.x + RND) >>> SHIFT) : (in_st.x >>> SHIFT);
    assign ys = in_st.y[XY_W-1] ? ((in_st.y + RND) >>> SHIFT) : (in_st.y >>> SHIFT);
    assign y_pos = !in_st.y[XY_W-1] && (in_st.y != '0);

    always_comb begin
        st_next = in_st;
        if (y_pos) begin
            st_next.x = in_st.x + ys;
            st_next.y = in_st.y - xs;
            st_next.z = in_st.z + ATAN;
        end else begin
            st_next.x = in_st.x - ys;
            st_next.y = in_st.y + xs;
            st_next.z = in_st.z - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;

endmodule

// File: hdl/accel_tilt_pitch_roll_alarm_top.sv
// Top level of the accelerometer pitch, roll and tilt alarm pipeline.
//
// Usage: one transaction on the s_ channel carries a signed x, y, z sample.
// One transaction on the m_ channel returns pitch and roll in whole degrees
// (-90..90, truncated toward zero) and a tilt error flag that is set when
// either magnitude exceeds the limit held in the configuration register.
// The limit is written through cfg_wr_en / cfg_wr_data and resets to 30.
//
// The path holds 56 register stages: 3 front stages (magnitude, square, sum),
// 32 square root digit cells, 20 CORDIC cells and the output register. The
// first stage loads at the accepting edge. A new sample is accepted every
// cycle while s_ready is high; the pitch and roll lanes each have their own
// chain of root and CORDIC cells.
// When the receiver stalls, the whole pipeline holds its contents and s_ready
// falls until the output register is taken. Synchronous reset empties the
// pipeline and the output register and restores the limit.
module accel_tilt_pitch_roll_alarm_top (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [acc_tilt_pkg::SAMPLE_W-1:0] s_accel_x,
    input  logic signed [acc_tilt_pkg::SAMPLE_W-1:0] s_accel_y,
    input  logic signed [acc_tilt_pkg::SAMPLE_W-1:0] s_accel_z,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [acc_tilt_pkg::DEG_W-1:0]    m_pitch_deg,
    output logic signed [acc_tilt_pkg::DEG_W-1:0]    m_roll_deg,
    output logic                                     m_tilt_error,
    input  logic                                     cfg_wr_en,
    input  logic [acc_tilt_pkg::LIMIT_W-1:0]         cfg_wr_data
);
    import acc_tilt_pkg::*;

    logic                      en;
    logic                      front_valid;
    sqrt_state_t               front_pitch, front_roll;
    logic                      sq_vld [2][SQRT_STEPS+1];
    sqrt_state_t               sq_st  [2][SQRT_STEPS+1];
    logic                      co_vld [2][CORDIC_ITERS+1];
    cordic_state_t             co_st  [2][CORDIC_ITERS+1];

    logic [LIMIT_W-1:0]        limit_reg;
    logic                      m_valid_reg;
    logic signed [DEG_W-1:0]   pitch_reg, roll_reg;
    logic                      tilt_reg;

    logic signed [DEG_W-1:0]   pitch_next, roll_next;
    logic [LIMIT_W-1:0]        pmag, rmag;
    logic                      tail_valid;

    // Final angle magnitude: zero and right-angle special cases, bias, floor at zero, drop the fraction, saturate.
    function automatic logic [LIMIT_W-1:0] angle_mag(input cordic_state_t s);
        logic signed [Z_W-1:0]       zb;
        logic [Z_W-ANGLE_FRAC-1:0]   q;
        logic [LIMIT_W-1:0]          m;
        zb = s.z + TRUNC_BIAS;
        q  = zb[Z_W-1:ANGLE_FRAC];
        if (s.info.num_zero) begin
            m = '0;
        end else if (s.info.den_zero) begin
            m = RIGHT_ANGLE;
        end else if (zb[Z_W-1]) begin
            m = '0;
        end else if (q > (Z_W-ANGLE_FRAC)'(RIGHT_ANGLE)) begin
            m = RIGHT_ANGLE;
        end else begin
            m = q[LIMIT_W-1:0];
        end
        return m;
    endfunction

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    acc_tilt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_x      (s_accel_x),
        .in_y      (s_accel_y),
        .in_z      (s_accel_z),
        .out_valid (front_valid),
        .out_pitch (front_pitch),
        .out_roll  (front_roll)
    );

    assign sq_vld[0][0] = front_valid;
    assign sq_vld[1][0] = front_valid;
    assign sq_st[0][0]  = front_pitch;
    assign sq_st[1][0]  = front_roll;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
            acc_tilt_sqrt_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (sq_vld[l][k]),
                .in_st     (sq_st[l][k]),
                .out_valid (sq_vld[l][k+1]),
                .out_st    (sq_st[l][k+1])
            );
        end

        // CORDIC entry: X is the root, Y the numerator magnitude in Q16.
        assign co_vld[l][0]     = sq_vld[l][SQRT_STEPS];
        assign co_st[l][0].x    = signed'(XY_W'(sq_st[l][SQRT_STEPS].root));
        assign co_st[l][0].y    = signed'(XY_W'({sq_st[l][SQRT_STEPS].info.mag,
                                                 {ANGLE_FRAC{1'b0}}}));
        assign co_st[l][0].z    = '0;
        assign co_st[l][0].info = sq_st[l][SQRT_STEPS].info;

        for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
            acc_tilt_cordic_cell #(
                .SHIFT (i)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (co_vld[l][i]),
                .in_st     (co_st[l][i]),
                .out_valid (co_vld[l][i+1]),
                .out_st    (co_st[l][i+1])
            );
        end
    end

    assign tail_valid = co_vld[0][CORDIC_ITERS] && co_vld[1][CORDIC_ITERS];
    assign pmag       = angle_mag(co_st[0][CORDIC_ITERS]);
    assign rmag       = angle_mag(co_st[1][CORDIC_ITERS]);
    assign pitch_next = co_st[0][CORDIC_ITERS].info.neg ? -signed'(DEG_W'(pmag))
                                                        : signed'(DEG_W'(pmag));
    assign roll_next  = co_st[1][CORDIC_ITERS].info.neg ? -signed'(DEG_W'(rmag))
                                                        : signed'(DEG_W'(rmag));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (en) begin
                m_valid_reg <= tail_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && tail_valid) begin
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
            tilt_reg  <= (pmag > limit_reg) || (rmag > limit_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pitch_deg  = pitch_reg;
    assign m_roll_deg   = roll_reg;
    assign m_tilt_error = tilt_reg;

endmodule

// File: hdl/acc_tilt_checker.sv
// Port-level checker for the tilt monitor, bound to the top level.
module acc_tilt_checker (
    input logic                                     aclk,
    input logic                                     aresetn,
    input logic                                     s_ready,
    input logic                                     m_valid,
    input logic                                     m_ready,
    input logic signed [acc_tilt_pkg::DEG_W-1:0]    m_pitch_deg,
    input logic signed [acc_tilt_pkg::DEG_W-1:0]    m_roll_deg,
    input logic                                     m_tilt_error
);
    import acc_tilt_pkg::*;

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pitch_deg) &&
                                   $stable(m_roll_deg) && $stable(m_tilt_error)))
        else $error("result changed while stalled");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_deg >= -8'sd90 && m_pitch_deg <= 8'sd90 &&
                     m_roll_deg >= -8'sd90 && m_roll_deg <= 8'sd90))
        else $error("angle out of range");

    // A tilt error needs a nonzero angle, since the limit is never negative.
    a_tilt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tilt_error) |-> (m_pitch_deg != '0 || m_roll_deg != '0))
        else $error("tilt error with level angles");

    // A stalled full output register must block the input side.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while output stalled");

endmodule

bind accel_tilt_pitch_roll_alarm_top acc_tilt_checker u_acc_tilt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_pitch_deg  (m_pitch_deg),
    .m_roll_deg   (m_roll_deg),
    .m_tilt_error (m_tilt_error)
);
